// ===== rtl/u8ncf_pkg.sv =====
// Shared types, constants and classification helpers of the UTF-8 name filter.
`default_nettype none

package u8ncf_pkg;

  // Held bytes of one open character group and the most results one byte can cause.
  localparam int HELD_DEPTH = 6;

  // Entries in the request queue between the front and the back part.
  localparam int QDEPTH = 4;

  // Accepted range of a three-byte character, taken as one 24-bit number.
  localparam logic [23:0] CJK_LO = 24'hE4B880;
  localparam logic [23:0] CJK_HI = 24'hE9BEBB;

  // ASCII bounds of the kept single-byte characters.
  localparam logic [7:0] CH_DIGIT_LO = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI = 8'h39;
  localparam logic [7:0] CH_UPPER_LO = 8'h41;
  localparam logic [7:0] CH_UPPER_HI = 8'h5A;
  localparam logic [7:0] CH_LOWER_LO = 8'h61;
  localparam logic [7:0] CH_LOWER_HI = 8'h7A;

  // The only group length that can hold a kept character.
  localparam logic [2:0] CJK_LEN = 3'd3;

  // One request: up to HELD_DEPTH results that one accepted byte causes.
  typedef struct packed {
    logic [2:0]                  cnt;    // number of results, 1 to HELD_DEPTH
    logic                        hb;     // results carry bytes
    logic [HELD_DEPTH-1:0][7:0]  bytes;  // result bytes, first at index 0
    logic                        done;   // last result closes the name
    logic                        ill;    // verdict of the name
  } rec_t;

  // Count of leading one bits among bits 7..1 of a lead byte.
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] n;
    logic       run;
    n   = 3'd0;
    run = 1'b1;
    for (int i = 7; i >= 1; i--) begin
      if (run && b[i]) begin
        n = n + 3'd1;
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

  // Digit or Latin letter.
  function automatic logic is_alnum(input logic [7:0] b);
    return (b >= CH_DIGIT_LO && b <= CH_DIGIT_HI) ||
           (b >= CH_UPPER_LO && b <= CH_UPPER_HI) ||
           (b >= CH_LOWER_LO && b <= CH_LOWER_HI);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/u8ncf_front.sv =====
// Front part: accepts name bytes, tracks the open character group and builds requests.
`default_nettype none

module u8ncf_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic             full,
  input  wire logic [7:0]       in_byte,
  input  wire logic             in_end_of_name,
  input  wire logic             filter_en,
  output logic                  rec_push,
  output u8ncf_pkg::rec_t       rec
);

  logic [u8ncf_pkg::HELD_DEPTH-1:0][7:0] gb_r, gb_nxt, bytes;
  logic [2:0] glen_r, glen_nxt;
  logic [2:0] gcnt_r, gcnt_nxt;
  logic       ill_r, ill_nxt, ill_name;
  logic [2:0] len;
  logic [2:0] n;
  logic       accept;
  logic       group_end;

  assign accept = push & ~full;
  assign len    = u8ncf_pkg::lead_length(in_byte);
  assign group_end = (({1'b0, gcnt_r} + 4'd1) == {1'b0, glen_r});

  // Classify the byte against the open group and work out the results it causes.
  always_comb begin
    gb_nxt   = gb_r;
    glen_nxt = glen_r;
    gcnt_nxt = gcnt_r;
    ill_nxt  = ill_r;
    n        = 3'd0;
    bytes    = '0;
    if (glen_r == 3'd0) begin
      if (len == 3'd0) begin
        if (u8ncf_pkg::is_alnum(in_byte)) begin
          bytes[0] = in_byte;
          n        = filter_en ? 3'd1 : 3'd0;
        end else begin
          ill_nxt = 1'b1;
        end
      end else if (len == 3'd1) begin
        ill_nxt = 1'b1;
      end else begin
        glen_nxt  = len;
        gb_nxt[0] = in_byte;
        gcnt_nxt  = 3'd1;
      end
    end else if (group_end) begin
      if (glen_r == u8ncf_pkg::CJK_LEN &&
          {gb_r[0], gb_r[1], in_byte} >= u8ncf_pkg::CJK_LO &&
          {gb_r[0], gb_r[1], in_byte} <= u8ncf_pkg::CJK_HI) begin
        bytes[0] = gb_r[0];
        bytes[1] = gb_r[1];
        bytes[2] = in_byte;
        n        = filter_en ? 3'd3 : 3'd0;
      end else begin
        ill_nxt = 1'b1;
      end
      glen_nxt = 3'd0;
      gcnt_nxt = 3'd0;
    end else begin
      if (gcnt_r < 3'(u8ncf_pkg::HELD_DEPTH)) begin
        gb_nxt[gcnt_r] = in_byte;
      end
      gcnt_nxt = gcnt_r + 3'd1;
    end

    // A group cut off by the end of the name is illegal and passes through as held.
    if (in_end_of_name && glen_nxt != 3'd0) begin
      ill_nxt = 1'b1;
      if (filter_en) begin
        n     = gcnt_nxt;
        bytes = gb_nxt;
      end
    end
    ill_name = ill_nxt;

    // Group state and verdict start over with the next name.
    if (in_end_of_name) begin
      glen_nxt = 3'd0;
      gcnt_nxt = 3'd0;
      ill_nxt  = 1'b0;
    end
  end

  // Request record: a byte-less marker closes a name that emits nothing on its last byte.
  always_comb begin
    rec.bytes = bytes;
    rec.done  = in_end_of_name;
    rec.ill   = ill_name;
    if (n == 3'd0) begin
      rec.hb  = 1'b0;
      rec.cnt = 3'd1;
    end else begin
      rec.hb  = 1'b1;
      rec.cnt = n;
    end
  end

  assign rec_push = accept & (in_end_of_name | (n != 3'd0));

  // Group control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glen_r <= 3'd0;
      gcnt_r <= 3'd0;
      ill_r  <= 1'b0;
    end else if (accept) begin
      glen_r <= glen_nxt;
      gcnt_r <= gcnt_nxt;
      ill_r  <= ill_nxt;
    end
  end

  // Held bytes of the open group.
  always_ff @(posedge clk) begin
    if (accept) begin
      gb_r <= gb_nxt;
    end
  end

  // The received byte count stays below the group length while a group is open.
  a_cnt_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (glen_r != 3'd0) |-> (gcnt_r < glen_r))
    else $error("group count reached group length");

  // No group is left open after the last byte of a name.
  a_name_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_end_of_name) |=> (glen_r == 3'd0 && gcnt_r == 3'd0 && !ill_r))
    else $error("group state survived the end of a name");

endmodule

`default_nettype wire

// ===== rtl/u8ncf_queue.sv =====
// Request queue between the front and the back part.
`default_nettype none

module u8ncf_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  wire u8ncf_pkg::rec_t wr_rec,
  input  wire logic            rd_en,
  output logic                 q_full,
  output logic                 q_empty,
  output u8ncf_pkg::rec_t      head
);

  localparam int PW = (u8ncf_pkg::QDEPTH > 1) ? $clog2(u8ncf_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(u8ncf_pkg::QDEPTH + 1);

  u8ncf_pkg::rec_t mem_r [u8ncf_pkg::QDEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_wr, do_rd;

  assign q_full  = (cnt_r == CW'(u8ncf_pkg::QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en & ~q_full;
  assign do_rd   = rd_en & ~q_empty;
  assign head    = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(u8ncf_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(u8ncf_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_rec;
    end
  end

  // The fill count never exceeds the depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(u8ncf_pkg::QDEPTH))
    else $error("queue overfilled");

  // A write without a read grows the fill count by one.
  a_cnt_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not follow a write");

endmodule

`default_nettype wire

// ===== rtl/u8ncf_back.sv =====
// Back part: expands the oldest request into result items, one per cycle in which pop is high.
`default_nettype none

module u8ncf_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_empty,
  input  wire u8ncf_pkg::rec_t head,
  output logic                 q_pop,
  input  wire logic            pop,
  output logic                 empty,
  output logic                 out_has_byte,
  output logic [7:0]           out_byte,
  output logic                 out_name_done,
  output logic                 out_illegal_seen
);

  logic [2:0] idx_r, idx_nxt;
  logic       last;
  logic       take;

  assign empty = q_empty;
  assign last  = ((idx_r + 3'd1) == head.cnt);
  assign take  = pop & ~q_empty;
  assign q_pop = take & last;

  // Result fields of the current position within the head request.
  assign out_has_byte     = head.hb;
  assign out_byte         = head.hb ? head.bytes[idx_r] : 8'd0;
  assign out_name_done    = head.done & last;
  assign out_illegal_seen = head.ill & head.done & last;

  // Step through the results; move on to the next request after the last one.
  always_comb begin
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = last ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // The result position stays inside the head request.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> (idx_r < head.cnt))
    else $error("result position beyond request");

  // The position rests at zero while nothing waits.
  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> (idx_r == 3'd0))
    else $error("result position left over with empty queue");

endmodule

`default_nettype wire

// ===== rtl/utf8_name_character_filter_unit.sv =====
// Top level of the UTF-8 name character filter.
`default_nettype none

// Filters the bytes of a UTF-8 name, keeping digits, Latin letters and three-byte
// characters in the range E4B880..E9BEBB, and reports on the last result of each name
// whether any other or cut-off character occurred. A byte is accepted in every cycle
// in which push is high and full is low; the front part classifies it at once and
// places its results (up to six) as one request in a four-entry queue. The back part
// hands out the results of the head request one per cycle in which pop is high. The
// sustained byte rate is one per cycle while pop stays high and each byte causes at
// most one result; a byte that causes several results holds the result side until
// all are taken. With cfg_filter_enable low only the verdict of each name is
// delivered. Write the configuration only while no name is in progress.

module utf8_name_character_filter_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_filter_enable,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end_of_name,
  output logic            empty,
  input  wire logic       pop,
  output logic            out_has_byte,
  output logic [7:0]      out_byte,
  output logic            out_name_done,
  output logic            out_illegal_seen
);

  logic            filter_en_r;
  logic            rec_push;
  u8ncf_pkg::rec_t rec;
  u8ncf_pkg::rec_t head;
  logic            q_full, q_empty, q_pop;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      filter_en_r <= cfg_filter_enable;
    end
  end

  assign full = q_full;

  u8ncf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (q_full),
    .in_byte        (in_byte),
    .in_end_of_name (in_end_of_name),
    .filter_en      (filter_en_r),
    .rec_push       (rec_push),
    .rec            (rec)
  );

  u8ncf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (rec_push),
    .wr_rec  (rec),
    .rd_en   (q_pop),
    .q_full  (q_full),
    .q_empty (q_empty),
    .head    (head)
  );

  u8ncf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .head             (head),
    .q_pop            (q_pop),
    .pop              (pop),
    .empty            (empty),
    .out_has_byte     (out_has_byte),
    .out_byte         (out_byte),
    .out_name_done    (out_name_done),
    .out_illegal_seen (out_illegal_seen)
  );

endmodule

`default_nettype wire
